FILE: src/telnet_iac_stream_parser_core_defines.svh
// Assertion macros shared by the parser modules.
`ifndef TELNET_IAC_STREAM_PARSER_CORE_DEFINES_SVH
`define TELNET_IAC_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define TISP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TISP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tisp_pkg.sv
`timescale 1ns / 1ps
package tisp_pkg;

	localparam logic [7:0] B_IAC  = 8'hFF;
	localparam logic [7:0] B_WILL = 8'hFB;
	localparam logic [7:0] B_WONT = 8'hFC;
	localparam logic [7:0] B_DO   = 8'hFD;
	localparam logic [7:0] B_DONT = 8'hFE;
	localparam logic [7:0] B_SB   = 8'hFA;
	localparam logic [7:0] B_SE   = 8'hF0;
	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SGA  = 8'd3;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic REG_RAW_MODE    = 1'b0;
	localparam logic REG_CRLF_ENABLE = 1'b1;

	typedef enum logic [1:0] {
		KIND_TERM    = 2'd0,
		KIND_TERM_CR = 2'd1,
		KIND_REPLY   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic [7:0] verb;
	} cmd_t;

endpackage

FILE: src/tisp_front.sv
`timescale 1ns / 1ps
`include "telnet_iac_stream_parser_core_defines.svh"
module tisp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          raw_mode,
	input  logic          crlf_enable,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          push,
	output tisp_pkg::cmd_t push_cmd
);

	typedef enum logic [2:0] {
		ST_DATA   = 3'd0,
		ST_IAC    = 3'd1,
		ST_OPT    = 3'd2,
		ST_SB     = 3'd3,
		ST_SB_IAC = 3'd4
	} state_t;

	localparam logic [1:0] VERB_WILL = 2'd0;
	localparam logic [1:0] VERB_DO   = 2'd2;

	state_t     state_q, state_d;
	logic [1:0] pend_q, pend_d;
	logic       prev_cr_q;
	logic       term_en, reply_en, accept;
	logic [7:0] term_byte, reply_verb;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d    = state_q;
		pend_d     = pend_q;
		term_en    = 1'b0;
		term_byte  = in_byte;
		reply_en   = 1'b0;
		reply_verb = tisp_pkg::B_WONT;
		if (raw_mode) begin
			term_en = 1'b1;
		end else begin
			unique case (state_q)
				ST_IAC: begin
					if (in_byte == tisp_pkg::B_IAC) begin
						state_d   = ST_DATA;
						term_en   = 1'b1;
						term_byte = tisp_pkg::B_IAC;
					end else if (in_byte >= tisp_pkg::B_WILL) begin
						pend_d  = 2'(in_byte - tisp_pkg::B_WILL);
						state_d = ST_OPT;
					end else if (in_byte == tisp_pkg::B_SB) begin
						state_d = ST_SB;
					end else begin
						state_d = ST_DATA;
					end
				end
				ST_OPT: begin
					state_d = ST_DATA;
					if (pend_q == VERB_WILL) begin
						reply_en   = 1'b1;
						reply_verb = (in_byte == tisp_pkg::OPT_ECHO ||
							in_byte == tisp_pkg::OPT_SGA) ? tisp_pkg::B_DO : tisp_pkg::B_DONT;
					end else if (pend_q == VERB_DO) begin
						reply_en   = 1'b1;
						reply_verb = (in_byte == tisp_pkg::OPT_SGA) ?
							tisp_pkg::B_WILL : tisp_pkg::B_WONT;
					end
				end
				ST_SB: begin
					if (in_byte == tisp_pkg::B_IAC)
						state_d = ST_SB_IAC;
				end
				ST_SB_IAC: begin
					state_d = (in_byte == tisp_pkg::B_SE) ? ST_DATA : ST_SB;
				end
				default: begin
					if (in_byte == tisp_pkg::B_IAC) begin
						state_d = ST_IAC;
					end else begin
						state_d = ST_DATA;
						term_en = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		push_cmd.data = term_byte;
		push_cmd.verb = reply_verb;
		if (reply_en)
			push_cmd.kind = tisp_pkg::KIND_REPLY;
		else if (crlf_enable && term_byte == tisp_pkg::CH_LF && !prev_cr_q)
			push_cmd.kind = tisp_pkg::KIND_TERM_CR;
		else
			push_cmd.kind = tisp_pkg::KIND_TERM;
	end

	assign push = accept && (term_en || reply_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_DATA;
			pend_q    <= 2'd0;
			prev_cr_q <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (term_en)
				prev_cr_q <= (term_byte == tisp_pkg::CH_CR);
		end
	end

	`TISP_ASSERT_NEXT(a_opt_returns_to_data, accept && !raw_mode && state_q == ST_OPT,
		state_q == ST_DATA, "option byte did not end the command")
	`TISP_ASSERT_NEXT(a_raw_holds_state, accept && raw_mode, $stable(state_q),
		"parse state moved in raw mode")

endmodule

FILE: src/tisp_queue.sv
`timescale 1ns / 1ps
`include "telnet_iac_stream_parser_core_defines.svh"
module tisp_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tisp_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output tisp_pkg::cmd_t rd_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tisp_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	`TISP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`TISP_ASSERT_NOW(a_no_lost_push, push, !full, "request pushed into a full queue")

endmodule

FILE: src/tisp_back.sv
`timescale 1ns / 1ps
`include "telnet_iac_stream_parser_core_defines.svh"
module tisp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  tisp_pkg::cmd_t q_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_net,
	output logic           out_last
);

	logic [1:0] idx_q;
	logic       valid_q, net_q, last_q;
	logic [7:0] byte_q;
	logic [7:0] beat_byte;
	logic       beat_net, beat_last, load;

	always_comb begin
		beat_byte = q_cmd.data;
		beat_net  = 1'b0;
		beat_last = 1'b1;
		case (q_cmd.kind)
			tisp_pkg::KIND_TERM_CR: begin
				beat_last = (idx_q != 2'd0);
				beat_byte = (idx_q == 2'd0) ? tisp_pkg::CH_CR : q_cmd.data;
			end
			tisp_pkg::KIND_REPLY: begin
				beat_net  = 1'b1;
				beat_last = (idx_q == 2'd2);
				case (idx_q)
					2'd0:    beat_byte = tisp_pkg::B_IAC;
					2'd1:    beat_byte = q_cmd.verb;
					default: beat_byte = q_cmd.data;
				endcase
			end
			default: begin
				beat_byte = q_cmd.data;
			end
		endcase
	end

	assign load = q_valid && (!valid_q || out_ready);
	assign pop  = load && beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= beat_last ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= beat_byte;
			net_q  <= beat_net;
			last_q <= beat_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_net   = net_q;
	assign out_last  = last_q;

	`TISP_ASSERT_NEXT(a_reply_contiguous, valid_q && net_q && !last_q && out_ready,
		valid_q && net_q, "reply sequence broken")
	`TISP_ASSERT_NOW(a_idx_range, 1'b1, idx_q != 2'd3, "beat index out of range")

endmodule

FILE: src/telnet_iac_stream_parser_core.sv
`timescale 1ns / 1ps
// Telnet receive parser. Bytes enter on s_axis one per cycle while the request
// queue has room; the front end tracks IAC commands and subnegotiation and queues
// a request for each byte that yields output. The back end drains one request at
// a time through a single output register at one result per cycle while not
// stalled by m_axis_tready: a plain byte gives one result, a CR-inserted LF two
// (CR, LF), a negotiation reply three (IAC, verb, option on tuser=1). Consumed
// bytes queue no request. Registers: 0x0 raw_mode, 0x4 crlf_enable.
module telnet_iac_stream_parser_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tuser,   // [0] to_network
	output logic        m_axis_tlast
);

	logic raw_mode_q, crlf_enable_q;
	logic q_full, push, pop, q_valid;
	tisp_pkg::cmd_t push_cmd, q_cmd;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q    <= 1'b0;
			crlf_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == tisp_pkg::REG_RAW_MODE)
				raw_mode_q <= pwdata[0];
			else
				crlf_enable_q <= pwdata[0];
		end
	end

	assign prdata = {31'd0,
		(paddr[2] == tisp_pkg::REG_CRLF_ENABLE) ? crlf_enable_q : raw_mode_q};

	tisp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_mode    (raw_mode_q),
		.crlf_enable (crlf_enable_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	tisp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	tisp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_net   (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: tb/tb_telnet_iac_stream_parser_core.sv
`timescale 1ns / 1ps
module tb_telnet_iac_stream_parser_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [2:0] {
		PS_DATA,
		PS_IAC,
		PS_OPT,
		PS_SB,
		PS_SB_IAC
	} parse_state_t;

	typedef enum logic [1:0] {
		VERB_WILL = 2'd0,
		VERB_WONT = 2'd1,
		VERB_DO   = 2'd2,
		VERB_DONT = 2'd3
	} verb_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       to_network;
		logic       out_last;
	} parser_out_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] out_byte
	logic        m_axis_tuser;   // [0] to_network
	logic        m_axis_tlast;

	parser_out_t  parser_out_q[$];
	parse_state_t model_state;
	verb_t        model_verb;
	logic         model_prev_cr;
	logic         model_raw;
	logic         model_crlf;
	logic         idle_on;
	int           fail_count;
	int           rx_sent;
	int           cycle_count;

	telnet_iac_stream_parser_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !idle_on || ($urandom_range(99) >= 17);
	end

	// result checker
	always @(posedge clk) begin
		parser_out_t exp_out;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (parser_out_q.size() == 0) begin
				$error("unexpected result: out_byte %h to_network %b last %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				exp_out = parser_out_q.pop_front();
				if (m_axis_tdata !== exp_out.out_byte) begin
					$error("out_byte: expected %h, got %h", exp_out.out_byte, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tuser !== exp_out.to_network) begin
					$error("to_network: expected %b, got %b", exp_out.to_network,
						m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tlast !== exp_out.out_last) begin
					$error("last: expected %b, got %b", exp_out.out_last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	function automatic void push_out(input logic [7:0] b, input logic net, input logic fin);
		parser_out_t r;
		r.out_byte = b;
		r.to_network = net;
		r.out_last = fin;
		parser_out_q = {parser_out_q, r};
	endfunction

	function automatic void emit_terminal(input logic [7:0] b);
		if (model_crlf && b == tisp_pkg::CH_LF && !model_prev_cr)
			push_out(tisp_pkg::CH_CR, 1'b0, 1'b0);
		push_out(b, 1'b0, 1'b1);
		model_prev_cr = (b == tisp_pkg::CH_CR);
	endfunction

	function automatic void emit_reply(input logic [7:0] verb, input logic [7:0] opt);
		push_out(tisp_pkg::B_IAC, 1'b1, 1'b0);
		push_out(verb, 1'b1, 1'b0);
		push_out(opt, 1'b1, 1'b1);
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b);
		logic [7:0] verb_off;
		verb_off = b - tisp_pkg::B_WILL;
		if (model_raw) begin
			emit_terminal(b);
		end else begin
			case (model_state)
				PS_IAC: begin
					if (b == tisp_pkg::B_IAC) begin
						model_state = PS_DATA;
						emit_terminal(tisp_pkg::B_IAC);
					end else if (b >= tisp_pkg::B_WILL) begin
						model_verb = verb_t'(verb_off[1:0]);
						model_state = PS_OPT;
					end else if (b == tisp_pkg::B_SB) begin
						model_state = PS_SB;
					end else begin
						model_state = PS_DATA;
					end
				end
				PS_OPT: begin
					model_state = PS_DATA;
					if (model_verb == VERB_WILL) begin
						if (b == tisp_pkg::OPT_ECHO || b == tisp_pkg::OPT_SGA)
							emit_reply(tisp_pkg::B_DO, b);
						else
							emit_reply(tisp_pkg::B_DONT, b);
					end else if (model_verb == VERB_DO) begin
						if (b == tisp_pkg::OPT_SGA)
							emit_reply(tisp_pkg::B_WILL, b);
						else
							emit_reply(tisp_pkg::B_WONT, b);
					end
				end
				PS_SB: begin
					if (b == tisp_pkg::B_IAC)
						model_state = PS_SB_IAC;
				end
				PS_SB_IAC: begin
					model_state = (b == tisp_pkg::B_SE) ? PS_DATA : PS_SB;
				end
				default: begin
					if (b == tisp_pkg::B_IAC) begin
						model_state = PS_IAC;
					end else begin
						model_state = PS_DATA;
						emit_terminal(b);
					end
				end
			endcase
		end
	endfunction

	task automatic send_rx_byte(input logic [7:0] b);
		while (idle_on && $urandom_range(99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		parse_rx_byte(b);
		rx_sent++;
	endtask

	task automatic send_rx_bytes(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_rx_byte(seq[i]);
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (parser_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_idx, input logic [31:0] value);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == tisp_pkg::REG_RAW_MODE)
			model_raw = value[0];
		else
			model_crlf = value[0];
	endtask

	task automatic test_terminal_bytes();
		send_rx_bytes('{8'h00, 8'h7F, 8'hFE, tisp_pkg::B_IAC, tisp_pkg::B_IAC});
	endtask

	task automatic test_negotiation();
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_WILL, tisp_pkg::OPT_ECHO,
			tisp_pkg::B_IAC, tisp_pkg::B_WILL, tisp_pkg::B_IAC});
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_DO, tisp_pkg::OPT_SGA,
			tisp_pkg::B_IAC, tisp_pkg::B_DO, tisp_pkg::OPT_ECHO});
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_WONT, tisp_pkg::OPT_SGA,
			tisp_pkg::B_IAC, tisp_pkg::B_DONT, tisp_pkg::OPT_ECHO, tisp_pkg::B_IAC, 8'hF1});
	endtask

	task automatic test_subnegotiation();
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_SB, 8'h18, tisp_pkg::B_IAC,
			tisp_pkg::B_IAC, tisp_pkg::B_IAC, 8'h41, tisp_pkg::B_IAC, tisp_pkg::B_SE, 8'h42});
	endtask

	task automatic test_crlf_insertion();
		apb_write(tisp_pkg::REG_CRLF_ENABLE, 32'd1);
		send_rx_bytes('{tisp_pkg::CH_LF, tisp_pkg::CH_CR, tisp_pkg::CH_LF, tisp_pkg::CH_CR,
			tisp_pkg::B_IAC, 8'hF1, tisp_pkg::CH_LF, 8'h61, tisp_pkg::CH_LF});
		// IAC IAC leaves 0xFF as the previous terminal byte
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_IAC, tisp_pkg::CH_LF});
	endtask

	task automatic test_raw_mid_command();
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_WILL});
		apb_write(tisp_pkg::REG_RAW_MODE, 32'd1);
		send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::CH_LF, tisp_pkg::CH_CR, tisp_pkg::CH_LF});
		apb_write(tisp_pkg::REG_CRLF_ENABLE, 32'd0);
		send_rx_bytes('{tisp_pkg::CH_LF, 8'h80});
		apb_write(tisp_pkg::REG_RAW_MODE, 32'd0);
		send_rx_bytes('{tisp_pkg::OPT_ECHO, tisp_pkg::CH_LF});
	endtask

	task automatic send_random_sequence();
		int k;
		int n;
		logic [7:0] opt;
		k = $urandom_range(99);
		if (model_raw) begin
			if (k < 20)
				send_rx_byte(tisp_pkg::CH_LF);
			else if (k < 35)
				send_rx_byte(tisp_pkg::CH_CR);
			else
				send_rx_byte(8'($urandom_range(255)));
		end else if (k < 35) begin
			send_rx_byte(8'($urandom_range(254)));
		end else if (k < 45) begin
			if ($urandom_range(1))
				send_rx_byte(tisp_pkg::CH_CR);
			send_rx_byte(tisp_pkg::CH_LF);
		end else if (k < 50) begin
			send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_IAC});
		end else if (k < 75) begin
			opt = $urandom_range(1) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
			send_rx_bytes('{tisp_pkg::B_IAC, 8'(tisp_pkg::B_WILL + $urandom_range(3)), opt});
		end else if (k < 82) begin
			send_rx_bytes('{tisp_pkg::B_IAC, 8'($urandom_range(8'hF9))});
		end else if (k < 92) begin
			send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_SB});
			n = $urandom_range(6);
			repeat (n) begin
				case ($urandom_range(5))
					0: send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_IAC});
					1: send_rx_bytes('{tisp_pkg::B_IAC, 8'($urandom_range(8'hEF))});
					default: send_rx_byte(8'($urandom_range(254)));
				endcase
			end
			send_rx_bytes('{tisp_pkg::B_IAC, tisp_pkg::B_SE});
		end else begin
			send_rx_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic random_phase(input logic raw, input logic crlf, input int n_bytes);
		int stop_at;
		apb_write(tisp_pkg::REG_RAW_MODE, {31'd0, raw});
		apb_write(tisp_pkg::REG_CRLF_ENABLE, {31'd0, crlf});
		stop_at = rx_sent + n_bytes;
		while (rx_sent < stop_at)
			send_random_sequence();
	endtask

	task automatic test_random_traffic();
		random_phase(1'b0, 1'b0, 55);
		wait_results_drained();
		random_phase(1'b0, 1'b0, 25);
		idle_on = 1'b0;
		random_phase(1'b0, 1'b1, 70);
		idle_on = 1'b1;
		random_phase(1'b1, 1'b1, 30);
		random_phase(1'b1, 1'b0, 25);
		random_phase(1'b0, 1'b1, 65);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_on = 1'b1;
		fail_count = 0;
		rx_sent = 0;
		model_state = PS_DATA;
		model_verb = VERB_WILL;
		model_prev_cr = 1'b0;
		model_raw = 1'b0;
		model_crlf = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_terminal_bytes();
		test_negotiation();
		test_subnegotiation();
		test_crlf_insertion();
		test_raw_mid_command();
		test_random_traffic();

		wait_results_drained();
		repeat (20) @(posedge clk);
		if (parser_out_q.size() != 0) begin
			$error("%0d results never arrived", parser_out_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
